@@ rtl/core/opa_pkg.sv @@
package opa_pkg;

    // Pool geometry
    localparam int POOL_SIZE = 64;
    localparam int IDX_W     = 6;
    localparam int CNT_W     = 7;
    localparam int SEQ_W     = 32;
    localparam int STAT_W    = 3;
    localparam int MODE_W    = 2;
    localparam int OPT_W     = 2;

    localparam logic [CNT_W-1:0] POOL_CNT = CNT_W'(POOL_SIZE);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POOL_SIZE - 1);

    // Item modes
    localparam logic [MODE_W-1:0] MODE_ACQ = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REL = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PRE = 2'd2;

    // Empty-pool options
    localparam logic [OPT_W-1:0] OPT_FAIL   = 2'd0;
    localparam logic [OPT_W-1:0] OPT_CREATE = 2'd1;
    localparam logic [OPT_W-1:0] OPT_RECALL = 2'd2;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
    localparam logic [STAT_W-1:0] ST_NONE      = 3'd1;
    localparam logic [STAT_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STAT_W-1:0] ST_NOUSE     = 3'd3;
    localparam logic [STAT_W-1:0] ST_NOTINUSE  = 3'd4;
    localparam logic [STAT_W-1:0] ST_BADCNT    = 3'd5;

    // Controller to datapath commands
    typedef struct packed {
        logic              load;
        logic              pop_rd;
        logic              grant_pop;
        logic              grant_create;
        logic              grant_recall;
        logic              push_rel;
        logic              pre_step;
        logic              scan_init;
        logic              scan_step;
        logic              set_status;
        logic [STAT_W-1:0] status;
        logic              out_load;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [OPT_W-1:0]  opt;
        logic              can_pop;
        logic              can_create;
        logic              rel_ok;
        logic              target_zero;
        logic              can_prewarm;
        logic              pre_short;
        logic              scan_done;
        logic              found;
        logic              out_free;
    } stat_t;

endpackage

@@ rtl/core/opa_req_if.sv @@
interface opa_req_if;
    logic                         valid;
    logic                         ready;
    logic [opa_pkg::MODE_W-1:0]   mode;
    logic [opa_pkg::IDX_W-1:0]    handle;
    logic [opa_pkg::CNT_W-1:0]    target_count;

    modport source (output valid, mode, handle, target_count, input ready);
    modport sink   (input valid, mode, handle, target_count, output ready);
endinterface

@@ rtl/core/opa_rsp_if.sv @@
interface opa_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [opa_pkg::STAT_W-1:0]   status;
    logic [opa_pkg::IDX_W-1:0]    granted_handle;
    logic                         recalled;
    logic                         newly_created;
    logic [opa_pkg::CNT_W-1:0]    created_now;

    modport source (output valid, status, granted_handle, recalled, newly_created,
                    created_now, input ready);
    modport sink   (input valid, status, granted_handle, recalled, newly_created,
                    created_now, output ready);
endinterface

@@ rtl/core/opa_ctrl.sv @@
module opa_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  opa_pkg::stat_t stat,
    output opa_pkg::cmd_t  cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DISP   = 3'd1;
    localparam logic [2:0] S_POPRD  = 3'd2;
    localparam logic [2:0] S_POPGR  = 3'd3;
    localparam logic [2:0] S_SCAN   = 3'd4;
    localparam logic [2:0] S_RECALL = 3'd5;
    localparam logic [2:0] S_PRE    = 3'd6;
    localparam logic [2:0] S_FINISH = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign in_ready = (state_reg == S_IDLE);

    // Sequence the work of one word
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                state_next = S_FINISH;
                unique case (stat.mode)
                    opa_pkg::MODE_ACQ:
                    begin
                        if (stat.can_pop)
                        begin
                            state_next = S_POPRD;
                        end
                        else if (stat.opt == opa_pkg::OPT_CREATE)
                        begin
                            if (stat.can_create)
                            begin
                                cmd.grant_create = 1'b1;
                            end
                            else
                            begin
                                cmd.set_status = 1'b1;
                                cmd.status     = opa_pkg::ST_FULL;
                            end
                        end
                        else if (stat.opt == opa_pkg::OPT_RECALL)
                        begin
                            cmd.scan_init = 1'b1;
                            state_next    = S_SCAN;
                        end
                        else
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status     = opa_pkg::ST_NONE;
                        end
                    end
                    opa_pkg::MODE_REL:
                    begin
                        if (stat.rel_ok)
                        begin
                            cmd.push_rel = 1'b1;
                        end
                        else
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status     = opa_pkg::ST_NOTINUSE;
                        end
                    end
                    opa_pkg::MODE_PRE:
                    begin
                        if (stat.target_zero)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status     = opa_pkg::ST_BADCNT;
                        end
                        else
                        begin
                            state_next = S_PRE;
                        end
                    end
                    default:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end
            S_POPRD:
            begin
                cmd.pop_rd = 1'b1;
                state_next = S_POPGR;
            end
            S_POPGR:
            begin
                cmd.grant_pop = 1'b1;
                state_next    = S_FINISH;
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_done)
                begin
                    state_next = S_RECALL;
                end
            end
            S_RECALL:
            begin
                if (stat.found)
                begin
                    cmd.grant_recall = 1'b1;
                end
                else
                begin
                    cmd.set_status = 1'b1;
                    cmd.status     = opa_pkg::ST_NOUSE;
                end
                state_next = S_FINISH;
            end
            S_PRE:
            begin
                if (stat.can_prewarm)
                begin
                    cmd.pre_step = 1'b1;
                end
                else
                begin
                    if (stat.pre_short)
                    begin
                        cmd.set_status = 1'b1;
                        cmd.status     = opa_pkg::ST_FULL;
                    end
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

`ifndef ASSERT_OFF
    // The result register is only loaded when it can take the word
    assert property (@(posedge clk) disable iff (!rst_n) cmd.out_load |-> stat.out_free)
        else $error("result loaded while output is blocked");
    // A pop read is always followed by its grant
    assert property (@(posedge clk) disable iff (!rst_n)
                     (state_reg == S_POPRD) |=> (state_reg == S_POPGR))
        else $error("pop read not followed by grant");
    // A new word is taken only from idle and leads to dispatch
    assert property (@(posedge clk) disable iff (!rst_n) cmd.load |=> (state_reg == S_DISP))
        else $error("load did not reach dispatch");
`endif

endmodule

@@ rtl/core/opa_dp.sv @@
module opa_dp (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [opa_pkg::OPT_W-1:0]    cfg_wdata,
    input  logic [opa_pkg::MODE_W-1:0]   in_mode,
    input  logic [opa_pkg::IDX_W-1:0]    in_handle,
    input  logic [opa_pkg::CNT_W-1:0]    in_target,
    input  opa_pkg::cmd_t                cmd,
    output opa_pkg::stat_t               stat,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [opa_pkg::STAT_W-1:0]   out_status,
    output logic [opa_pkg::IDX_W-1:0]    out_granted,
    output logic                         out_recalled,
    output logic                         out_created,
    output logic [opa_pkg::CNT_W-1:0]    out_created_now
);

    // Configuration and pool state
    logic [opa_pkg::OPT_W-1:0]     opt_reg;
    logic [opa_pkg::CNT_W-1:0]     ready_count_reg;
    logic [opa_pkg::CNT_W-1:0]     created_reg;
    logic [opa_pkg::SEQ_W-1:0]     next_seq_reg;
    logic [opa_pkg::POOL_SIZE-1:0] marks_reg;

    // Latched item
    logic [opa_pkg::MODE_W-1:0]    mode_reg;
    logic [opa_pkg::IDX_W-1:0]     handle_reg;
    logic [opa_pkg::CNT_W-1:0]     target_reg;

    // Working result
    logic [opa_pkg::STAT_W-1:0]    res_status_reg;
    logic [opa_pkg::IDX_W-1:0]     res_granted_reg;
    logic                          res_recalled_reg;
    logic                          res_created_reg;
    logic [opa_pkg::CNT_W-1:0]     res_count_reg;

    // Output register
    logic                          out_valid_reg;
    logic [opa_pkg::STAT_W-1:0]    out_status_reg;
    logic [opa_pkg::IDX_W-1:0]     out_granted_reg;
    logic                          out_recalled_reg;
    logic                          out_created_reg;
    logic [opa_pkg::CNT_W-1:0]     out_count_reg;

    // Memories
    logic [opa_pkg::IDX_W-1:0]     stack_mem [opa_pkg::POOL_SIZE];
    logic [opa_pkg::SEQ_W-1:0]     seq_mem   [opa_pkg::POOL_SIZE];
    logic [opa_pkg::IDX_W-1:0]     stack_rdata_reg;
    logic [opa_pkg::SEQ_W-1:0]     seq_rdata_reg;

    // Oldest search
    logic [opa_pkg::CNT_W-1:0]     issue_idx_reg;
    logic                          rd_valid_reg;
    logic [opa_pkg::IDX_W-1:0]     rd_idx_reg;
    logic                          found_reg;
    logic [opa_pkg::IDX_W-1:0]     best_idx_reg;
    logic [opa_pkg::SEQ_W-1:0]     best_seq_reg;

    logic                          any_grant;
    logic [opa_pkg::IDX_W-1:0]     grant_h;
    logic [opa_pkg::SEQ_W-1:0]     seq_next;
    logic                          push_en;
    logic [opa_pkg::IDX_W-1:0]     push_data;
    logic [opa_pkg::CNT_W-1:0]     rc_dec;
    logic                          scan_issue;
    logic                          rd_hit;
    logic                          out_free;

    assign any_grant  = cmd.grant_pop || cmd.grant_create || cmd.grant_recall;
    assign seq_next   = next_seq_reg + 1'b1;
    assign push_en    = cmd.push_rel || cmd.pre_step;
    assign push_data  = cmd.push_rel ? handle_reg : created_reg[opa_pkg::IDX_W-1:0];
    assign rc_dec     = ready_count_reg - 1'b1;
    assign scan_issue = cmd.scan_step && (issue_idx_reg < opa_pkg::POOL_CNT);
    assign rd_hit     = rd_valid_reg && marks_reg[rd_idx_reg]
                        && (!found_reg || (seq_rdata_reg < best_seq_reg));
    assign out_free   = !out_valid_reg || out_ready;

    // Pick the handle being granted
    always_comb
    begin
        priority if (cmd.grant_pop)
        begin
            grant_h = stack_rdata_reg;
        end
        else if (cmd.grant_create)
        begin
            grant_h = created_reg[opa_pkg::IDX_W-1:0];
        end
        else
        begin
            grant_h = best_idx_reg;
        end
    end

    // Report conditions to the controller
    always_comb
    begin
        stat.mode        = mode_reg;
        stat.opt         = opt_reg;
        stat.can_pop     = (ready_count_reg != '0);
        stat.can_create  = (created_reg < opa_pkg::POOL_CNT);
        stat.rel_ok      = marks_reg[handle_reg] && (ready_count_reg < opa_pkg::POOL_CNT);
        stat.target_zero = (target_reg == '0);
        stat.pre_short   = (created_reg < target_reg);
        stat.can_prewarm = (created_reg < target_reg) && (created_reg < opa_pkg::POOL_CNT)
                           && (ready_count_reg < opa_pkg::POOL_CNT);
        stat.scan_done   = rd_valid_reg && (rd_idx_reg == opa_pkg::LAST_IDX);
        stat.found       = found_reg;
        stat.out_free    = out_free;
    end

    // Ready stack memory
    always_ff @(posedge clk)
    begin
        if (push_en)
        begin
            stack_mem[ready_count_reg[opa_pkg::IDX_W-1:0]] <= push_data;
        end
        if (cmd.pop_rd)
        begin
            stack_rdata_reg <= stack_mem[rc_dec[opa_pkg::IDX_W-1:0]];
        end
    end

    // Sequence memory
    always_ff @(posedge clk)
    begin
        if (any_grant)
        begin
            seq_mem[grant_h] <= seq_next;
        end
        if (scan_issue)
        begin
            seq_rdata_reg <= seq_mem[issue_idx_reg[opa_pkg::IDX_W-1:0]];
        end
    end

    // Pool control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            opt_reg         <= opa_pkg::OPT_FAIL;
            ready_count_reg <= '0;
            created_reg     <= '0;
            next_seq_reg    <= '0;
            marks_reg       <= '0;
            issue_idx_reg   <= '0;
            rd_valid_reg    <= 1'b0;
            found_reg       <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                opt_reg <= cfg_wdata;
            end
            // Advance counters
            if (cmd.pop_rd)
            begin
                ready_count_reg <= rc_dec;
            end
            else if (push_en)
            begin
                ready_count_reg <= ready_count_reg + 1'b1;
            end
            if (cmd.grant_create || cmd.pre_step)
            begin
                created_reg <= created_reg + 1'b1;
            end
            // Mark grants and releases
            if (any_grant)
            begin
                next_seq_reg       <= seq_next;
                marks_reg[grant_h] <= 1'b1;
            end
            else if (cmd.push_rel)
            begin
                marks_reg[handle_reg] <= 1'b0;
            end
            // Walk the sequence memory for the oldest user
            if (cmd.scan_init)
            begin
                issue_idx_reg <= '0;
                rd_valid_reg  <= 1'b0;
                found_reg     <= 1'b0;
            end
            else
            begin
                rd_valid_reg <= scan_issue;
                if (scan_issue)
                begin
                    issue_idx_reg <= issue_idx_reg + 1'b1;
                end
                if (rd_hit)
                begin
                    found_reg <= 1'b1;
                end
            end
            // Hold result until taken
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Item, search and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg         <= in_mode;
            handle_reg       <= in_handle;
            target_reg       <= in_target;
            res_status_reg   <= opa_pkg::ST_OK;
            res_granted_reg  <= '0;
            res_recalled_reg <= 1'b0;
            res_created_reg  <= 1'b0;
            res_count_reg    <= '0;
        end
        if (scan_issue)
        begin
            rd_idx_reg <= issue_idx_reg[opa_pkg::IDX_W-1:0];
        end
        if (rd_hit)
        begin
            best_idx_reg <= rd_idx_reg;
            best_seq_reg <= seq_rdata_reg;
        end
        if (any_grant)
        begin
            res_granted_reg  <= grant_h;
            res_recalled_reg <= cmd.grant_recall;
            res_created_reg  <= cmd.grant_create;
        end
        if (cmd.pre_step)
        begin
            res_count_reg <= res_count_reg + 1'b1;
        end
        if (cmd.set_status)
        begin
            res_status_reg <= cmd.status;
        end
        if (cmd.out_load)
        begin
            out_status_reg   <= res_status_reg;
            out_granted_reg  <= res_granted_reg;
            out_recalled_reg <= res_recalled_reg;
            out_created_reg  <= res_created_reg;
            out_count_reg    <= res_count_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_status      = out_status_reg;
    assign out_granted     = out_granted_reg;
    assign out_recalled    = out_recalled_reg;
    assign out_created     = out_created_reg;
    assign out_created_now = out_count_reg;

`ifndef ASSERT_OFF
    // Ready handles are always a subset of created handles
    assert property (@(posedge clk) disable iff (!rst_n) ready_count_reg <= created_reg)
        else $error("ready count exceeds created count");
    // Created count never passes the pool size
    assert property (@(posedge clk) disable iff (!rst_n) created_reg <= opa_pkg::POOL_CNT)
        else $error("created count beyond pool size");
    // A granted handle is marked in use right after the grant
    assert property (@(posedge clk) disable iff (!rst_n)
                     any_grant |=> marks_reg[res_granted_reg])
        else $error("granted handle not marked in use");
    // Releases only happen for handles in use
    assert property (@(posedge clk) disable iff (!rst_n)
                     cmd.push_rel |-> marks_reg[handle_reg])
        else $error("release of handle not in use");
`endif

endmodule

@@ rtl/core/object_pool_allocator_top.sv @@
// Object pool allocator: one word in, one result word out.
// A stack pop reads the ready stack and then grants; a recall scans the sequence
// memory (one read per cycle) for the oldest handle in use; a prewarm creates
// handles until the created count reaches the target or the pool is full.
// One word is worked at a time; the next word is accepted once the result is loaded.
// Reset clears the in-use marks, counters and option at once; no clearing pass.
module object_pool_allocator_top (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [opa_pkg::OPT_W-1:0] cfg_wdata,
    opa_req_if.sink                   req,
    opa_rsp_if.source                 rsp
);

    opa_pkg::cmd_t  cmd;
    opa_pkg::stat_t stat;

    // Sequence each word
    opa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Hold pool state and the result register
    opa_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .in_mode         (req.mode),
        .in_handle       (req.handle),
        .in_target       (req.target_count),
        .cmd             (cmd),
        .stat            (stat),
        .out_valid       (rsp.valid),
        .out_ready       (rsp.ready),
        .out_status      (rsp.status),
        .out_granted     (rsp.granted_handle),
        .out_recalled    (rsp.recalled),
        .out_created     (rsp.newly_created),
        .out_created_now (rsp.created_now)
    );

endmodule
